[sv/ogcm_pkg.sv]
package ogcm_pkg;
    localparam int MaxChannelsDef = 8;
    localparam int MaxFramesDef = 4096;
    localparam int SampleW = 24;
    localparam int OutW = 16;
    localparam int GainW = 16;
    localparam int CountW = 4;
    localparam int ChW = 3;
    localparam int SumW = 43;
    localparam int FrameW = 13;
    localparam logic [GainW-1:0] GainUnity = 16'd32768;
    localparam logic [CountW-1:0] CountReset = 4'd2;
    localparam logic [1:0] RegGain = 2'd0;
    localparam logic [1:0] RegCount = 2'd1;
    localparam logic KindSample = 1'b0;
    localparam logic KindMeter = 1'b1;

    typedef struct packed {
        logic [ChW-1:0] ch;
        logic [OutW-1:0] peak;
        logic [SumW-1:0] sum;
        logic [FrameW-1:0] frames;
        logic last;
    } t_meter_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;
endpackage

[sv/ogcm_if.sv]
interface ogcm_in_if;
    logic valid;
    logic ready;
    logic signed [23:0] sample_in;
    logic [2:0] channel;
    logic end_of_block;
    modport source(output valid, sample_in, channel, end_of_block, input ready);
    modport sink(input valid, sample_in, channel, end_of_block, output ready);
endinterface

interface ogcm_out_if;
    logic valid;
    logic ready;
    logic kind;
    logic [2:0] out_channel;
    logic signed [15:0] out_sample;
    logic [15:0] peak_level;
    logic [15:0] rms_level;
    logic last;
    modport source(output valid, kind, out_channel, out_sample, peak_level, rms_level, last,
                   input ready);
    modport sink(input valid, kind, out_channel, out_sample, peak_level, rms_level, last,
                 output ready);
endinterface

[sv/ogcm_back.sv]
// Divide (restoring, 1 bit/cycle) then square root (1 step/cycle) per meter job.
module ogcm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  ogcm_pkg::t_meter_job  i_job,
    output logic                  o_job_ready,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [2:0]            o_res_ch,
    output logic [15:0]           o_res_peak,
    output logic [15:0]           o_res_rms,
    output logic                  o_res_last
);
    import ogcm_pkg::*;

    t_back_state r_state, n_state;
    t_meter_job r_job;
    logic [SumW-1:0] r_quo, r_rem_q;
    logic [FrameW:0] r_rem;
    logic [5:0] r_cnt;
    logic [SumW:0] r_v, r_res, r_bit;
    logic [15:0] r_rms;
    logic [FrameW:0] w_trial;
    logic [SumW:0] w_sum;

    always_comb begin
        w_trial = {r_rem[FrameW-1:0], r_rem_q[SumW-1]};
        w_sum = r_res + r_bit;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == 6'd0) n_state = ST_SQRT;
            ST_SQRT: if (r_bit == '0) n_state = ST_OUT;
            ST_OUT:  if (i_res_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == ST_IDLE);
        o_res_valid = (r_state == ST_OUT);
        o_res_ch = r_job.ch;
        o_res_peak = r_job.peak;
        o_res_rms = r_rms;
        o_res_last = r_job.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
                r_rem_q <= i_job.sum;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'(SumW);
            end
            ST_DIV: begin
                if (r_cnt != 6'd0) begin
                    r_rem_q <= r_rem_q << 1;
                    if (r_job.frames != '0 && w_trial >= {1'b0, r_job.frames}) begin
                        r_rem <= w_trial - {1'b0, r_job.frames};
                        r_quo <= {r_quo[SumW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[SumW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    r_v <= {1'b0, r_quo};
                    r_res <= '0;
                    r_bit <= (SumW+1)'(1) << 42;
                end
            end
            ST_SQRT: begin
                if (r_bit != '0) begin
                    if (r_v >= w_sum) begin
                        r_v <= r_v - w_sum;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_rms <= (r_res > (SumW+1)'(32768)) ? 16'd32768 : r_res[15:0];
                end
            end
            default: ;
        endcase
    end
endmodule

[sv/ogcm_front.sv]
// Gain, clip, accumulate; issues sample beats and meter jobs.
module ogcm_front #(
    parameter int MAX_CHANNELS = ogcm_pkg::MaxChannelsDef,
    parameter int MAX_FRAMES = ogcm_pkg::MaxFramesDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_gain,
    input  logic [3:0]            i_count,
    ogcm_in_if.sink               in_ch,
    output logic                  o_smp_valid,
    input  logic                  i_smp_ready,
    output logic [2:0]            o_smp_ch,
    output logic signed [15:0]    o_smp,
    output logic                  o_smp_last,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output ogcm_pkg::t_meter_job  o_job,
    output logic                  o_busy
);
    import ogcm_pkg::*;
    localparam int Cap = (MAX_FRAMES < 8191) ? MAX_FRAMES : 8191;
    localparam int McW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [SumW-1:0] SumMax = '1;

    logic [OutW-1:0] r_peak [MAX_CHANNELS];
    logic [SumW-1:0] r_sum [MAX_CHANNELS];
    logic [FrameW-1:0] r_frames;
    logic r_have, r_eob, r_met;
    logic [ChW-1:0] r_ch;
    logic signed [OutW-1:0] r_q;
    logic r_emit;
    logic [4:0] r_idx;
    logic [4:0] w_n;
    logic [15:0] w_g;
    logic signed [40:0] w_p;
    logic signed [25:0] w_sh;
    logic signed [OutW-1:0] w_q;
    logic [OutW-1:0] w_mag;
    logic [31:0] w_sq;
    logic [SumW:0] w_add;
    logic w_act;
    logic [McW-1:0] w_ci, w_ji;

    always_comb begin
        w_n = (i_count == 4'd0) ? 5'd1 :
              ({1'b0, i_count} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : {1'b0, i_count};
        w_g = (i_gain > GainUnity) ? GainUnity : i_gain;
        w_p = 41'(in_ch.sample_in) * $signed({1'b0, w_g});
        w_sh = 26'(w_p >>> 15);
        w_q = (w_sh > 26'sd32767) ? 16'sd32767 :
              (w_sh < -26'sd32768) ? -16'sd32768 : w_sh[15:0];
        w_mag = r_q[15] ? 16'(-{1'b0, r_q}) : r_q;
        w_sq = w_mag * w_mag;
        w_act = {2'b0, r_ch} < w_n;
        w_ci = McW'(r_ch);
        w_ji = McW'(r_idx);
        w_add = {1'b0, r_sum[w_ci]} + {12'b0, w_sq};
    end

    assign in_ch.ready = !r_have && !r_emit;
    assign o_smp_valid = r_have && r_met;
    assign o_smp_ch = r_ch;
    assign o_smp = r_q;
    assign o_smp_last = !r_eob;
    assign o_job_valid = r_emit;
    assign o_job.ch = r_idx[2:0];
    assign o_job.peak = r_peak[w_ji];
    assign o_job.sum = r_sum[w_ji];
    assign o_job.frames = r_frames;
    assign o_job.last = (r_idx == w_n - 5'd1);
    assign o_busy = r_have || r_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_met <= 1'b0;
            r_emit <= 1'b0;
            r_frames <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_peak[i] <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                r_have <= 1'b1;
                r_met <= 1'b0;
                r_q <= w_q;
                r_ch <= in_ch.channel;
                r_eob <= in_ch.end_of_block;
            end
            if (r_have && !r_met) begin
                r_met <= 1'b1;
                if (w_act) begin
                    if (w_mag > r_peak[w_ci]) r_peak[w_ci] <= w_mag;
                    r_sum[w_ci] <= w_add[SumW] ? SumMax : w_add[SumW-1:0];
                    if ({2'b0, r_ch} == w_n - 5'd1 && r_frames < FrameW'(Cap))
                        r_frames <= r_frames + 1'b1;
                end
            end
            if (o_smp_valid && i_smp_ready) begin
                r_have <= 1'b0;
                if (r_eob) begin
                    r_emit <= 1'b1;
                    r_idx <= '0;
                end
            end
            if (r_emit && i_job_ready) begin
                if (o_job.last) begin
                    r_emit <= 1'b0;
                    r_frames <= '0;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        r_peak[i] <= '0;
                        r_sum[i] <= '0;
                    end
                end
                r_idx <= r_idx + 5'd1;
            end
        end
    end
endmodule

[sv/output_gain_clip_meter.sv]
// Master gain, hard clip and per-channel peak/RMS meter. A sample is gained
// and clipped into a register as it is accepted, then accumulated, then sent as
// its output beat; the next sample is taken the cycle after that beat. A block
// end adds one meter beat per active channel; in the back end each one takes
// the job, runs a restoring divide by the frame count and a square root, and
// then presents the beat. Meter jobs wait in a 2-entry queue; the front takes
// no new sample until all jobs of the block are queued, and a sample beat
// waits until the back end has sent every meter beat.
module output_gain_clip_meter #(
    parameter int MAX_CHANNELS = ogcm_pkg::MaxChannelsDef,
    parameter int MAX_FRAMES = ogcm_pkg::MaxFramesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ogcm_in_if.sink     in_ch,
    ogcm_out_if.source  out_ch
);
    import ogcm_pkg::*;

    logic [GainW-1:0] r_gain;
    logic [CountW-1:0] r_count;
    logic w_wr;
    logic s_valid, s_ready, s_last, f_busy;
    logic [2:0] s_ch;
    logic signed [15:0] s_q;
    logic j_valid, j_ready, b_valid, b_ready, m_valid, m_ready, m_last;
    t_meter_job j_data, b_data;
    t_meter_job r_qd [2];
    logic [1:0] r_qn;
    logic r_qh;
    logic [2:0] m_ch;
    logic [15:0] m_peak, m_rms;
    logic w_pend, w_take_s;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            RegGain[0]:  prdata = {16'b0, r_gain};
            default:     prdata = {28'b0, r_count};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GainUnity;
            r_count <= CountReset;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == RegCount[0]) r_count <= pwdata[3:0];
            else r_gain <= pwdata[15:0];
        end
    end

    ogcm_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_FRAMES(MAX_FRAMES)) u_front (
        .i_clk, .i_rst_n, .i_gain(r_gain), .i_count(r_count), .in_ch,
        .o_smp_valid(s_valid), .i_smp_ready(s_ready), .o_smp_ch(s_ch), .o_smp(s_q),
        .o_smp_last(s_last), .o_job_valid(j_valid), .i_job_ready(j_ready),
        .o_job(j_data), .o_busy(f_busy)
    );

    // 2-entry job queue
    assign j_ready = (r_qn != 2'd2);
    assign b_valid = (r_qn != 2'd0);
    assign b_data = r_qd[r_qh];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= '0;
            r_qh <= 1'b0;
        end else begin
            if (j_valid && j_ready) r_qd[r_qh ^ r_qn[0]] <= j_data;
            if (b_valid && b_ready) r_qh <= ~r_qh;
            r_qn <= r_qn + 2'(j_valid && j_ready) - 2'(b_valid && b_ready);
        end
    end

    ogcm_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(b_valid), .i_job(b_data), .o_job_ready(b_ready),
        .o_res_valid(m_valid), .i_res_ready(m_ready), .o_res_ch(m_ch),
        .o_res_peak(m_peak), .o_res_rms(m_rms), .o_res_last(m_last)
    );

    // Meter beats of a block go out before any later sample beat.
    always_comb begin
        w_pend = b_valid || !b_ready;
        w_take_s = s_valid && !w_pend;
        m_ready = out_ch.ready && !w_take_s;
        s_ready = out_ch.ready && !w_pend;
        out_ch.valid = w_take_s || m_valid;
        out_ch.kind = w_take_s ? KindSample : KindMeter;
        out_ch.out_channel = w_take_s ? s_ch : m_ch;
        out_ch.out_sample = w_take_s ? s_q : 16'sd0;
        out_ch.peak_level = w_take_s ? 16'd0 : m_peak;
        out_ch.rms_level = w_take_s ? 16'd0 : m_rms;
        out_ch.last = w_take_s ? s_last : m_last;
    end

    a_qbound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_qn <= 2'd2)
        else $error("job queue overflow");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_busy |-> !in_ch.ready) else $error("front accepted while busy");
    a_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_valid |-> m_rms <= 16'd32768) else $error("rms out of range");
endmodule

[verif/tb_output_gain_clip_meter.sv]
`timescale 1ns / 100ps

module tb_output_gain_clip_meter;
    import ogcm_pkg::*;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [2:0] ch;
        logic eob;
    } t_in_beat;

    typedef struct packed {
        logic kind;
        logic [2:0] ch;
        logic signed [15:0] sample;
        logic [15:0] peak;
        logic [15:0] rms;
        logic last;
    } t_out_beat;

    localparam int FrameCap = (MaxFramesDef < 8191) ? MaxFramesDef : 8191;
    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
    localparam int WatchdogLimit = 20000;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ogcm_in_if in_ch();
    ogcm_out_if out_ch();

    output_gain_clip_meter dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    t_in_beat pending_q[$];
    t_out_beat expected_q[$];
    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int stall_cycles;
    logic timed_out;

    // predictor state
    logic [GainW-1:0] gain_reg;
    logic [CountW-1:0] count_reg;
    logic [15:0] peak_acc[MaxChannelsDef];
    logic [SumW-1:0] sum_acc[MaxChannelsDef];
    int frames;

    function automatic int unsigned floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return 32'(r);
    endfunction

    task automatic predict_beat(input t_in_beat b);
        longint s;
        longint p;
        longint q;
        longint g;
        int n;
        logic [15:0] mag;
        logic [63:0] sq;
        int unsigned rms;
        t_out_beat r;
        s = b.sample;
        g = (gain_reg > GainUnity) ? 32768 : gain_reg;
        p = s * g;
        q = p >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        mag = 16'((q < 0) ? -q : q);
        n = (count_reg == 0) ? 1 : (count_reg > MaxChannelsDef ? MaxChannelsDef : count_reg);
        if (b.ch < n) begin
            sq = 64'(mag) * 64'(mag);
            if (mag > peak_acc[b.ch]) peak_acc[b.ch] = mag;
            if ({21'd0, sum_acc[b.ch]} > {21'd0, SumMax} - sq) sum_acc[b.ch] = SumMax;
            else sum_acc[b.ch] = SumW'({21'd0, sum_acc[b.ch]} + sq);
            if (b.ch == n - 1 && frames < FrameCap) frames++;
        end
        r = '0;
        r.kind = KindSample;
        r.ch = b.ch;
        r.sample = q[15:0];
        r.last = !b.eob;
        expected_q = {expected_q, r};
        if (b.eob) begin
            for (int i = 0; i < n; i++) begin
                rms = 0;
                if (frames != 0) rms = floor_sqrt(64'(sum_acc[i]) / 64'(frames));
                if (rms > 32768) rms = 32768;
                r = '0;
                r.kind = KindMeter;
                r.ch = 3'(i);
                r.peak = peak_acc[i];
                r.rms = rms[15:0];
                r.last = (i == n - 1);
                expected_q = {expected_q, r};
            end
            for (int i = 0; i < MaxChannelsDef; i++) begin
                peak_acc[i] = 0;
                sum_acc[i] = 0;
            end
            frames = 0;
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_beat({in_ch.sample_in, in_ch.channel,
                                                          in_ch.end_of_block});
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_in_beat b;
                    b = pending_q.pop_front();
                    in_ch.valid <= 1;
                    in_ch.sample_in <= b.sample;
                    in_ch.channel <= b.ch;
                    in_ch.end_of_block <= b.eob;
                end else begin
                    in_ch.valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            stall_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_out_beat a;
                t_out_beat e;
                a = {out_ch.kind, out_ch.out_channel, out_ch.out_sample, out_ch.peak_level,
                     out_ch.rms_level, out_ch.last};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", a);
                end else begin
                    e = expected_q.pop_front();
                    if (a !== e) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp kind %0d ch %0d smp %0d pk %0d rms %0d last %0d",
                                     e.kind, e.ch, e.sample, e.peak, e.rms, e.last);
                            $display("          got kind %0d ch %0d smp %0d pk %0d rms %0d last %0d",
                                     a.kind, a.ch, a.sample, a.peak, a.rms, a.last);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx[0], 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == RegGain) gain_reg = val[15:0];
        else count_reg = val[3:0];
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic add_beat(input logic signed [23:0] s, input int ch, input logic eob);
        t_in_beat b;
        b.sample = s;
        b.ch = 3'(ch);
        b.eob = eob;
        pending_q = {pending_q, b};
    endtask

    // well-formed blocks with random content, some noise
    task automatic add_random(input int total, input int nch);
        int k;
        int frames_left;
        int c;
        logic signed [23:0] s;
        k = 0;
        while (k < total) begin
            frames_left = $urandom_range(1, 6);
            for (int f = 0; f < frames_left && k < total; f++) begin
                for (c = 0; c < nch && k < total; c++) begin
                    case ($urandom_range(3))
                        0: s = 24'($urandom);
                        1: s = 24'($signed($urandom_range(65535)) - 32768);
                        2: s = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
                        default: s = 24'($signed($urandom_range(8191)) - 4096);
                    endcase
                    if ($urandom_range(19) == 0)
                        add_beat(s, $urandom_range(7), $urandom_range(7) == 0);
                    else
                        add_beat(s, c, (f == frames_left - 1) && (c == nch - 1));
                    k++;
                end
            end
            if (k >= total) add_beat(24'($urandom), nch - 1, 1'b1);
        end
    endtask

    initial begin
        int gains[6];
        int counts[6];
        timed_out = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_ch.valid = 0;
        in_ch.sample_in = 0;
        in_ch.channel = 0;
        in_ch.end_of_block = 0;
        out_ch.ready = 0;
        gain_reg = GainUnity;
        count_reg = CountReset;
        frames = 0;
        for (int i = 0; i < MaxChannelsDef; i++) begin
            peak_acc[i] = 0;
            sum_acc[i] = 0;
        end
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset config, extremes, inactive channel, partial and empty blocks
        add_beat(24'sh7FFFFF, 0, 1'b0);
        add_beat(-24'sh800000, 1, 1'b0);
        add_beat(24'sd32768, 0, 1'b0);
        add_beat(-24'sd1, 1, 1'b0);
        add_beat(24'sd5, 5, 1'b0);
        add_beat(24'sd12345, 0, 1'b1);
        add_beat(24'sd0, 1, 1'b1);
        add_beat(-24'sd32768, 0, 1'b1);
        drain();
        apb_write(RegGain, 32'd65535);
        apb_write(RegCount, 32'd0);
        add_beat(-24'sd3, 0, 1'b0);
        add_beat(24'sh555555, 0, 1'b0);
        add_beat(24'shAAAAAA, 3, 1'b1);
        drain();
        apb_write(RegGain, 32'd0);
        apb_write(RegCount, 32'd15);
        for (int c = 0; c < 8; c++) add_beat(24'sh7FFFFF, c, c == 7);
        drain();
        apb_write(RegGain, 32'd1);
        apb_write(RegCount, 32'd8);
        add_beat(-24'sd1, 0, 1'b0);
        add_beat(24'sd40000, 7, 1'b1);
        drain();

        gains = '{32768, 16384, 0, 65535, 23170, 32767};
        counts = '{2, 8, 1, 5, 0, 15};
        for (int ph = 0; ph < 6; ph++) begin
            int nch;
            apb_write(RegGain, gains[ph]);
            apb_write(RegCount, counts[ph]);
            nch = (counts[ph] == 0) ? 1 : (counts[ph] > 8 ? 8 : counts[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 76; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 76; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            add_random(42, nch);
            while (pending_q.size() > 0) @(posedge i_clk);
            while (expected_q.size() > 0) @(posedge i_clk);
            add_random(42, nch);
            drain();
        end

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
